FILE: rtl/core/control_byte_hex_escaper_unit_assert.svh
// Assertion macros shared by the hex escaper RTL.
`ifndef CONTROL_BYTE_HEX_ESCAPER_UNIT_ASSERT_SVH
`define CONTROL_BYTE_HEX_ESCAPER_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define CBHE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CBHE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/cbhe_pkg.sv
// Package with the character codes, result group type and hex digit helper.
package cbhe_pkg;

  localparam int unsigned CfgW = 13;       // width of the buffer length register
  localparam int unsigned MaxGroup = 4;    // most output bytes one input byte causes
  localparam int unsigned NumW = 3;        // width of a group byte count

  localparam logic [7:0] CHR_NUL       = 8'h00;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_X         = 8'h78;
  localparam logic [7:0] CHR_DOT       = 8'h2E;
  localparam logic [7:0] PRINT_LO      = 8'h20;
  localparam logic [7:0] PRINT_HI      = 8'h7E;
  localparam logic [7:0] HIGH_LO       = 8'h80;
  localparam logic [7:0] HIGH_HI       = 8'hFF;

  // Output bytes caused by one input byte, element 0 goes out first.
  typedef struct packed {
    logic [MaxGroup-1:0][7:0] bytes;
    logic [NumW-1:0]          num;
    logic                     line_end;  // last byte of the group closes the line
  } grp_t;

  // Lower-case hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_digit = 8'h30 + ext;
    end else begin
      hex_digit = 8'h61 + ext - 8'd10;
    end
  endfunction

endpackage

FILE: rtl/core/cbhe_encode.sv
// Combinational encoder: maps one input byte and the line state to an output group.
module cbhe_encode #(
  parameter int unsigned CntW = 12,
  parameter int unsigned LenW = 13
) (
  input  logic [7:0]      in_byte_i,
  input  logic [CntW-1:0] count_i,
  input  logic [LenW-1:0] len_i,
  input  logic            trunc_i,
  output cbhe_pkg::grp_t  grp_o,
  output logic [CntW-1:0] count_o,
  output logic            trunc_o
);

  localparam int unsigned W = LenW + 1;

  logic [W-1:0] o_ext;
  logic [W-1:0] len_ext;
  logic [W-1:0] sum1;
  logic [W-1:0] sum3;
  logic [W-1:0] sum4;
  logic         fit1;
  logic         fit3;
  logic         fit4;
  logic         printable;

  assign o_ext   = W'(count_i);
  assign len_ext = W'(len_i);
  assign sum1    = o_ext + W'(1);
  assign sum3    = o_ext + W'(3);
  assign sum4    = o_ext + W'(4);
  assign fit1    = sum1 < len_ext;
  assign fit3    = sum3 < len_ext;
  assign fit4    = sum4 < len_ext;

  always_comb begin
    printable = in_byte_i inside {[cbhe_pkg::PRINT_LO:cbhe_pkg::PRINT_HI],
                                  [cbhe_pkg::HIGH_LO:cbhe_pkg::HIGH_HI]};
  end

  always_comb begin
    grp_o.bytes    = '0;
    grp_o.num      = '0;
    grp_o.line_end = 1'b0;
    count_o        = count_i;
    trunc_o        = trunc_i;
    if (trunc_i) begin
      // Skip the rest of a cut line; a zero reopens it.
      if (in_byte_i == cbhe_pkg::CHR_NUL) begin
        trunc_o = 1'b0;
        count_o = '0;
      end
    end else if (in_byte_i == cbhe_pkg::CHR_NUL) begin
      grp_o.bytes[0] = cbhe_pkg::CHR_NUL;
      grp_o.num      = cbhe_pkg::NumW'(1);
      grp_o.line_end = 1'b1;
      count_o        = '0;
    end else if (printable && fit1) begin
      grp_o.bytes[0] = in_byte_i;
      grp_o.num      = cbhe_pkg::NumW'(1);
      count_o        = sum1[CntW-1:0];
    end else if (!printable && fit4) begin
      grp_o.bytes[0] = cbhe_pkg::CHR_BACKSLASH;
      grp_o.bytes[1] = cbhe_pkg::CHR_X;
      grp_o.bytes[2] = cbhe_pkg::hex_digit(in_byte_i[7:4]);
      grp_o.bytes[3] = cbhe_pkg::hex_digit(in_byte_i[3:0]);
      grp_o.num      = cbhe_pkg::NumW'(4);
      count_o        = sum4[CntW-1:0];
    end else begin
      // Cut the line: an ellipsis or a single dot if room, then the terminator.
      grp_o.line_end = 1'b1;
      trunc_o        = 1'b1;
      if (fit3) begin
        grp_o.bytes[0] = cbhe_pkg::CHR_DOT;
        grp_o.bytes[1] = cbhe_pkg::CHR_DOT;
        grp_o.bytes[2] = cbhe_pkg::CHR_DOT;
        grp_o.bytes[3] = cbhe_pkg::CHR_NUL;
        grp_o.num      = cbhe_pkg::NumW'(4);
        count_o        = sum3[CntW-1:0];
      end else if (fit1) begin
        grp_o.bytes[0] = cbhe_pkg::CHR_DOT;
        grp_o.bytes[1] = cbhe_pkg::CHR_NUL;
        grp_o.num      = cbhe_pkg::NumW'(2);
        count_o        = sum1[CntW-1:0];
      end else begin
        grp_o.bytes[0] = cbhe_pkg::CHR_NUL;
        grp_o.num      = cbhe_pkg::NumW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/control_byte_hex_escaper_unit.sv
// Top level of the control byte hex escaper: stream ports, line state, output buffer.
//
// Usage:
//   s_axis carries one byte of a zero-terminated line per transaction. m_axis
//   returns the cleaned line one byte per transaction; m_axis_tuser marks the
//   terminating zero. cfg_* writes the output buffer length (0 acts as 1,
//   values above MAX_LINE_LEN clamp); write it only while the block is idle.
// Output: the first output byte of an input byte is registered and valid in the
//   cycle after its transaction.
// Throughput: printable bytes and terminators flow at one per cycle while
//   m_axis_tready stays high. An escape or an ellipsis with terminator emits
//   four bytes and a single dot with terminator two, and s_axis_tready stays
//   low until the last of them leaves. The four-entry output buffer sets this:
//   a new byte is taken once at most its last entry remains and that entry
//   leaves in the same cycle.
// Reset: clears the line count, the truncation flag and the buffer count, and sets
//   the buffer length to 4096 (or MAX_LINE_LEN if smaller).
// Stall: when m_axis_tready is low the current output byte holds and s_axis
//   stops taking bytes once the buffer holds output; nothing is dropped.
module control_byte_hex_escaper_unit #(
  parameter int unsigned MAX_LINE_LEN = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i,     // [12:0] out_buffer_len
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // output byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tuser    // [0] line_end
);

  `include "control_byte_hex_escaper_unit_assert.svh"

  localparam int unsigned CntW = $clog2(MAX_LINE_LEN);
  localparam int unsigned LenW = $clog2(MAX_LINE_LEN + 1);
  localparam int unsigned CmpW = (LenW > cbhe_pkg::CfgW) ? LenW : cbhe_pkg::CfgW;
  localparam int unsigned LenRst = (MAX_LINE_LEN < 4096) ? MAX_LINE_LEN : 4096;
  localparam int unsigned GrpN = cbhe_pkg::MaxGroup;
  localparam int unsigned NumW = cbhe_pkg::NumW;

  // Effective buffer length, line state and output buffer.
  logic [LenW-1:0]          len_q, len_d;
  logic [CntW-1:0]          count_q, count_d;
  logic                     trunc_q, trunc_d;
  logic [NumW-1:0]          cnt_q, cnt_d;
  logic [GrpN-1:0][7:0]     buf_q, buf_d;
  logic                     end_q, end_d;

  cbhe_pkg::grp_t           grp;
  logic [CntW-1:0]          enc_count;
  logic                     enc_trunc;
  logic                     in_acc;
  logic                     out_take;
  logic [CmpW-1:0]          cfg_ext;

  cbhe_encode #(
    .CntW (CntW),
    .LenW (LenW)
  ) u_encode (
    .in_byte_i (s_axis_tdata),
    .count_i   (count_q),
    .len_i     (len_q),
    .trunc_i   (trunc_q),
    .grp_o     (grp),
    .count_o   (enc_count),
    .trunc_o   (enc_trunc)
  );

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = buf_q[0];
  // Flag the terminator only on the group's last byte.
  assign m_axis_tuser  = end_q && (cnt_q == NumW'(1));
  assign out_take      = m_axis_tvalid && m_axis_tready;
  // Take a byte when the buffer is empty or drains this cycle.
  assign s_axis_tready = (cnt_q == '0) || ((cnt_q == NumW'(1)) && m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ext       = CmpW'(cfg_data_i);

  // Clamp the configured length into 1..MAX_LINE_LEN on write.
  always_comb begin
    len_d = len_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_ext == '0) begin
        len_d = LenW'(1);
      end else if (cfg_ext > CmpW'(MAX_LINE_LEN)) begin
        len_d = LenW'(MAX_LINE_LEN);
      end else begin
        len_d = cfg_ext[LenW-1:0];
      end
    end
  end

  // Advance line state and load or shift the output buffer.
  always_comb begin
    count_d = count_q;
    trunc_d = trunc_q;
    cnt_d   = cnt_q;
    buf_d   = buf_q;
    end_d   = end_q;
    if (in_acc) begin
      count_d = enc_count;
      trunc_d = enc_trunc;
      cnt_d   = grp.num;
      buf_d   = grp.bytes;
      end_d   = grp.line_end;
    end else if (out_take) begin
      cnt_d   = cnt_q - NumW'(1);
      buf_d   = {8'h00, buf_q[GrpN-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LenW'(LenRst);
      count_q <= '0;
      trunc_q <= 1'b0;
      cnt_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      len_q   <= len_d;
      count_q <= count_d;
      trunc_q <= trunc_d;
      cnt_q   <= cnt_d;
      end_q   <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  `CBHE_ASSERT(a_buf_bound, cnt_q <= NumW'(GrpN), "output buffer count above group size")
  `CBHE_ASSERT(a_end_is_nul,
               (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == cbhe_pkg::CHR_NUL),
               "line end on a non-zero byte")
  `CBHE_ASSERT(a_skip_silent,
               (s_axis_tvalid && s_axis_tready && trunc_q) |=> (cnt_q == '0),
               "byte of a cut line produced output")
  `CBHE_ASSERT(a_len_nonzero, len_q != '0, "effective buffer length is zero")

endmodule

FILE: tb/control_byte_hex_escaper_unit_checker.sv
// Line sanitizer checker: predicts the cleaned byte stream and compares each output transaction.
module control_byte_hex_escaper_unit_checker
  import cbhe_pkg::*;
#(
  parameter int unsigned MAX_LINE_LEN = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            s_tvalid_i,
  input  logic            s_tready_i,
  input  logic [7:0]      s_tdata_i,
  input  logic            m_tvalid_i,
  input  logic            m_tready_i,
  input  logic [7:0]      m_tdata_i,
  input  logic            m_tuser_i,
  output int              errors_o,
  output int              pending_o
);

  // Lower-case hex digits, digit 0 in the top byte.
  localparam logic [127:0] HexLc = "0123456789abcdef";

  typedef struct packed {
    logic [7:0] data;
    logic       line_end;
  } line_beat_t;

  line_beat_t      clean_line_q[$];
  logic [CfgW-1:0] buf_len;
  logic [11:0]     line_count;
  logic            line_cut;
  int              err_cnt;

  function automatic void add_beat(input logic [7:0] data, input logic line_end);
    line_beat_t beat;
    beat.data     = data;
    beat.line_end = line_end;
    clean_line_q.push_back(beat);
  endfunction

  // Apply one input byte to the line state and queue the bytes it produces.
  function automatic void sanitize_byte(input logic [7:0] c);
    int unsigned lim;
    int unsigned o;
    lim = buf_len;
    if (lim == 0) lim = 1;
    if (lim > MAX_LINE_LEN) lim = MAX_LINE_LEN;
    o = line_count;
    if (line_cut) begin
      // terminator already went out when the line was cut
      if (c == CHR_NUL) begin
        line_cut   = 1'b0;
        line_count = '0;
      end
      return;
    end
    if (c == CHR_NUL) begin
      add_beat(CHR_NUL, 1'b1);
      line_count = '0;
      return;
    end
    if ((c >= PRINT_LO && c <= PRINT_HI) || c >= HIGH_LO) begin
      if (o + 1 < lim) begin
        add_beat(c, 1'b0);
        line_count = 12'(o + 1);
        return;
      end
    end else if (o + 4 < lim) begin
      add_beat(CHR_BACKSLASH, 1'b0);
      add_beat(CHR_X, 1'b0);
      add_beat(HexLc[8*(15-c[7:4]) +: 8], 1'b0);
      add_beat(HexLc[8*(15-c[3:0]) +: 8], 1'b0);
      line_count = 12'(o + 4);
      return;
    end
    // no room left: close with an ellipsis or a single dot if either fits
    if (o + 3 < lim) begin
      add_beat(CHR_DOT, 1'b0);
      add_beat(CHR_DOT, 1'b0);
      add_beat(CHR_DOT, 1'b0);
      o = o + 3;
    end else if (o + 1 < lim) begin
      add_beat(CHR_DOT, 1'b0);
      o = o + 1;
    end
    add_beat(CHR_NUL, 1'b1);
    line_count = 12'(o);
    line_cut   = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    line_beat_t want;
    if (!rst_ni) begin
      clean_line_q.delete();
      buf_len    = 13'd4096;
      line_count = '0;
      line_cut   = 1'b0;
      err_cnt    = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        buf_len = cfg_data_i;
      end
      if (m_tvalid_i && m_tready_i) begin
        if (clean_line_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t: unexpected output byte %02h end %0b", $time, m_tdata_i, m_tuser_i);
          end
        end else begin
          want = clean_line_q.pop_front();
          if (want.data !== m_tdata_i || want.line_end !== m_tuser_i) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: output byte expected %02h end %0b, got %02h end %0b",
                       $time, want.data, want.line_end, m_tdata_i, m_tuser_i);
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        sanitize_byte(s_tdata_i);
      end
      errors_o  <= err_cnt;
      pending_o <= clean_line_q.size();
    end
  end

endmodule

FILE: tb/control_byte_hex_escaper_unit_tb.sv
// Testbench top for the hex escaper: stimulus, flow control and the final verdict.
module control_byte_hex_escaper_unit_tb;
  import cbhe_pkg::*;

  localparam int unsigned MaxLen = 4096;
  // cycles to let a zero-result transaction clear the block before a config write
  localparam int SettleCycles = 12;
  // length of the forced receiver hold-off, long enough to fill the output buffer
  localparam int HoldCycles = 120;
  localparam int PhaseItems = 50;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;
  logic            m_axis_tuser;

  int mismatches;
  int pending;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  // bump to request one long receiver hold-off
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int sent_in_phase = 0;

  always #5 clk_i = ~clk_i;

  control_byte_hex_escaper_unit #(
    .MAX_LINE_LEN(MaxLen)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  control_byte_hex_escaper_unit_checker #(
    .MAX_LINE_LEN(MaxLen)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .errors_o   (mismatches),
    .pending_o  (pending)
  );

  // Receiver: stall at random, or hold off for a long counted stretch on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_seen = hold_seq;
      hold_left = 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Offer one byte, idling first at the sender's rate, and hold it until the transaction.
  // tvalid stays high on return so back-to-back bytes need no extra assignment.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_in_phase++;
  endtask

  // Drop tvalid and wait until every predicted byte has come out, then let the block settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_len(input logic [CfgW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Non-zero line byte, weighted toward printable text with some escapes.
  function automatic logic [7:0] line_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return 8'($urandom_range(126, 32));
    if (pick < 75) return 8'($urandom_range(255, 128));
    if (pick < 80) return 8'h7F;
    return 8'($urandom_range(31, 1));
  endfunction

  // Well-formed line: n random non-zero bytes and the terminator.
  task automatic send_line(input int n);
    for (int i = 0; i < n; i++) send_byte(line_char());
    send_byte(CHR_NUL);
  endtask

  initial begin
    logic [CfgW-1:0] len_v;
    int              max_chars;
    int              pick;
    bit              paused;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default length, printable edges, high bytes, DEL and control escapes.
    send_byte(8'h41);
    send_byte(PRINT_LO);
    send_byte(PRINT_HI);
    send_byte(HIGH_LO);
    send_byte(HIGH_HI);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'h1F);
    send_byte(8'h0A);
    send_byte(CHR_NUL);
    send_byte(CHR_NUL);   // empty line

    // Length zero acts as one: terminator only, then skip up to the zero,
    // which itself produces nothing. The next zero is an empty line.
    drain_results();
    write_len('0);
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte(CHR_NUL);
    send_byte(CHR_NUL);

    // Escape that does not fit, room for a single dot.
    drain_results();
    write_len(13'd3);
    send_byte(8'h01);
    send_byte(CHR_NUL);

    // Escape that does not fit, room for the full ellipsis.
    drain_results();
    write_len(13'd4);
    send_byte(8'h1F);
    send_byte(CHR_NUL);

    // One byte fits, the next is cut with no room for any dot.
    drain_results();
    write_len(13'd2);
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte(CHR_NUL);

    // Length above the maximum clamps.
    drain_results();
    write_len(13'h1FFF);
    send_byte(8'h05);
    send_byte(PRINT_HI);
    send_byte(CHR_NUL);

    // Random phases: each with its own buffer length and one of four idling mixes.
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        0: len_v = 13'd1;
        1: len_v = 13'd8;
        2: len_v = 13'd16;
        3: len_v = '0;
        4: len_v = 13'($urandom_range(40, 2));
        5: len_v = 13'h1FFF;
        6: len_v = 13'd100;
        default: len_v = 13'($urandom_range(8191, 0));
      endcase
      write_len(len_v);
      case (ph % 4)
        0: begin
          src_idle_pct  <= 0;
          snk_stall_pct <= 0;
        end
        1: begin
          src_idle_pct  <= 54;
          snk_stall_pct <= 0;
        end
        2: begin
          src_idle_pct  <= 0;
          snk_stall_pct <= 54;
        end
        default: begin
          src_idle_pct  <= 20;
          snk_stall_pct <= 20;
        end
      endcase
      // Hold the receiver off while the sender keeps offering, so input backs up.
      if (ph == 1) hold_seq <= hold_seq + 1;
      max_chars = (ph == 6) ? 60 : 20;
      sent_in_phase = 0;
      paused = 1'b0;
      while (sent_in_phase < PhaseItems) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          send_line($urandom_range(max_chars, 0));
        end else if (pick < 95) begin
          // noise: any byte, zero included
          send_byte(8'($urandom_range(255, 0)));
        end else begin
          // broken line: random bytes, no terminator
          for (int i = $urandom_range(6, 1); i > 0; i--) send_byte(line_char());
        end
        // Pause the sender mid-phase until the output has fully caught up.
        if (ph == 5 && !paused && sent_in_phase > PhaseItems / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    if (mismatches == 0 && pending == 0) begin
      $display("control_byte_hex_escaper_unit: match");
    end else begin
      $display("control_byte_hex_escaper_unit: mismatch");
    end
    $finish;
  end

  // Timeout: a hung handshake or a missing byte ends the run here.
  initial begin
    #3000000;
    $display("control_byte_hex_escaper_unit: mismatch");
    $finish;
  end

endmodule
